[hw/rtl/mfc_pkg.sv]
// Shared types and constants for the majority frequency check block.
`default_nettype none

package mfc_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_TALLY = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_count;
      logic               has_majority;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/mfc_if.sv]
// Valid/ready channel interfaces for list elements and results.
`default_nettype none

interface mfc_req_if
   import mfc_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      is_final;

   modport source (output valid, output value, output is_final, input ready);
   modport sink (input valid, input value, input is_final, output ready);
endinterface

interface mfc_rsp_if
   import mfc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] max_count;
   logic               has_majority;

   modport source (output valid, output max_count, output has_majority, input ready);
   modport sink (input valid, input max_count, input has_majority, output ready);
endinterface

`default_nettype wire

[hw/rtl/majority_frequency_check_core.sv]
// Top level of the majority frequency check block.
// List elements enter on req_if one item per cycle and are written into an
// internal store of MAX_ITEMS entries; elements beyond that depth are dropped
// and the list is taken as its first MAX_ITEMS elements. The item flagged
// is_final closes the list and starts a counting pass, during which req_if
// is not ready: for each of the len stored elements the store's second read
// port sweeps all len entries, after which the result goes to the output
// register. One result per list then appears on rsp_if with the highest
// occurrence count and the majority flag (count greater than len/2, rounded
// down). The next list may load while that result waits to be taken. The
// store needs no clearing after reset.
`default_nettype none

module majority_frequency_check_core
   import mfc_pkg::*;
#(
   parameter int MAX_ITEMS = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   mfc_req_if.sink   req_if,
   mfc_rsp_if.source rsp_if
);

   localparam int AW = $clog2(MAX_ITEMS);

   logic               res_valid;
   logic               res_ready;
   result_type         res;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_a_addr;
   logic [AW-1:0]      rd_b_addr;
   logic [VALUE_W-1:0] rd_a_data;
   logic [VALUE_W-1:0] rd_b_data;

   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_data_ff, rsp_data_in;

   mfc_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   mfc_store #(.MAX_ITEMS(MAX_ITEMS)) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // output register frees the sequencer once the result is captured
   assign res_ready = !rsp_vld_ff || rsp_if.ready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (res_ready) begin
         rsp_vld_in  = res_valid;
         rsp_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.max_count    = rsp_data_ff.max_count;
   assign rsp_if.has_majority = rsp_data_ff.has_majority;

endmodule

`default_nettype wire

[hw/rtl/mfc_store.sv]
// Element store: one write port, two registered read ports.
`default_nettype none

module mfc_store
   import mfc_pkg::*;
#(
   parameter int MAX_ITEMS = 1024,
   localparam int AW = $clog2(MAX_ITEMS)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [VALUE_W-1:0] wr_data,
   input  wire logic [AW-1:0]      rd_a_addr,
   input  wire logic [AW-1:0]      rd_b_addr,
   output logic      [VALUE_W-1:0] rd_a_data,
   output logic      [VALUE_W-1:0] rd_b_data
);

   logic [VALUE_W-1:0] mem_q [MAX_ITEMS];
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_q[rd_a_addr];
      rd_b_ff <= mem_q[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

[hw/rtl/mfc_ctrl.sv]
// Load and counting sequencer: fills the store, then scans it pairwise.
`default_nettype none

module mfc_ctrl
   import mfc_pkg::*;
#(
   parameter int MAX_ITEMS = 1024,
   localparam int AW = $clog2(MAX_ITEMS),
   localparam int CW = $clog2(MAX_ITEMS + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   mfc_req_if.sink                 req_if,
   output logic                    res_valid,
   output result_type              res,
   input  wire logic               res_ready,
   output logic                    wr_en,
   output logic      [AW-1:0]      wr_addr,
   output logic      [VALUE_W-1:0] wr_data,
   output logic      [AW-1:0]      rd_a_addr,
   output logic      [AW-1:0]      rd_b_addr,
   input  wire logic [VALUE_W-1:0] rd_a_data,
   input  wire logic [VALUE_W-1:0] rd_b_data
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] hits_ff, hits_in;
   logic [CW-1:0] best_ff, best_in;
   logic          cmp_vld_ff, cmp_vld_in;

   logic          full;
   logic          eq;
   logic [CW-1:0] hits_sum;
   logic [CW-1:0] len_last;

   assign full     = (count_ff == FULL_COUNT);
   assign eq       = cmp_vld_ff && (rd_a_data == rd_b_data);
   assign hits_sum = hits_ff + CW'(eq);
   assign len_last = len_ff - CW'(1);

   assign req_if.ready = (state_ff == ST_LOAD);
   assign wr_addr      = count_ff[AW-1:0];
   assign wr_data      = req_if.value;
   assign rd_a_addr    = i_ff[AW-1:0];
   assign rd_b_addr    = j_ff[AW-1:0];

   assign res_valid        = (state_ff == ST_DONE);
   assign res.max_count    = COUNT_W'(best_ff);
   assign res.has_majority = (best_ff > (len_ff >> 1));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      hits_in    = hits_ff;
      best_in    = best_ff;
      cmp_vld_in = (state_ff == ST_SCAN);
      wr_en      = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_if.valid) begin
               // elements past a full store are dropped
               wr_en = !full;
               if (!full) begin
                  count_in = count_ff + CW'(1);
               end
               if (req_if.is_final) begin
                  len_in   = full ? count_ff : count_ff + CW'(1);
                  count_in = '0;
                  i_in     = '0;
                  j_in     = '0;
                  hits_in  = '0;
                  best_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            j_in    = j_ff + CW'(1);
            hits_in = hits_sum;
            if (j_ff == len_last) begin
               state_in = ST_TALLY;
            end
         end
         ST_TALLY: begin
            // last compare of this target lands here
            if (hits_sum > best_ff) begin
               best_in = hits_sum;
            end
            hits_in = '0;
            j_in    = '0;
            if (i_ff == len_last) begin
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         best_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         best_ff    <= best_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      hits_ff <= hits_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond store depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (i_ff < len_ff) && (j_ff < len_ff))
      else $error("scan address outside the list");

   a_tally_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TALLY) && (i_ff == len_last) |=> (state_ff == ST_DONE))
      else $error("pass did not finish after last target");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (best_ff <= len_ff) && (best_ff != '0))
      else $error("highest count out of range");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for majority_frequency_check_core: random lists, local count predictor.
`timescale 1ns / 1ps

module testbench
   import mfc_pkg::*;
   ();

   localparam int DEPTH         = 1024;
   localparam int HALF_DIV      = 2;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int OVERFLOW_LIST = 10;
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_AFTER    = 20;
   localparam int CALM_ITEMS    = 100;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 4000000;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               is_final;
   } list_elem_type;

   logic clock;
   logic reset;

   mfc_req_if req_ch ();
   mfc_rsp_if rsp_ch ();

   majority_frequency_check_core #(.MAX_ITEMS(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   list_elem_type      pending[$];
   result_type         expected_results[$];
   logic [VALUE_W-1:0] list_store[DEPTH];
   logic [VALUE_W-1:0] list_pool[3];
   int                 list_len = 0;
   int                 total_items = 0;
   int                 sent_count = 0;
   int                 results_seen = 0;
   int                 errors = 0;
   int                 cycle_count = 0;
   logic               calm = 1'b0;

   // driver state
   list_elem_type offered;
   int         gap_left = 0;
   int         idle_pct = 10;
   // receiver state
   int         hold_left = 0;
   int         stall_left = 0;
   int         stall_pct = 10;
   int         ready_cycles = 0;
   logic       hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic flag_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
   endtask

   // highest number of equal entries among the held elements
   function automatic int peak_occurrence();
      int top;
      int hits;
      top = 0;
      for (int i = 0; i < list_len; i++) begin
         hits = 0;
         for (int j = 0; j < list_len; j++)
            if (list_store[j] == list_store[i]) hits++;
         if (hits > top) top = hits;
      end
      return top;
   endfunction

   task automatic absorb_element(list_elem_type e);
      result_type r;
      int         peak;
      // elements past the store depth are dropped
      if (list_len < DEPTH) begin
         list_store[list_len] = e.value;
         list_len++;
      end
      if (e.is_final) begin
         peak = peak_occurrence();
         r.max_count = peak[COUNT_W-1:0];
         r.has_majority = (peak > list_len / HALF_DIV);
         expected_results.push_back(r);
         list_len = 0;
      end
   endtask

   task automatic push_elem(logic [VALUE_W-1:0] v, logic fin);
      list_elem_type e;
      e.value = v;
      e.is_final = fin;
      pending.push_back(e);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5, 6: return list_pool[$urandom_range(0, 2)];
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_random_list(int len);
      logic [VALUE_W-1:0] lead;
      int                 lead_pct;
      for (int k = 0; k < 3; k++)
         list_pool[k] = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 7);
      lead = pick_value();
      case ($urandom_range(0, 4))
         0: lead_pct = 0;
         1: lead_pct = 30;
         2: lead_pct = 50;
         3: lead_pct = 60;
         default: lead_pct = 90;
      endcase
      for (int k = 0; k < len; k++)
         push_elem(($urandom_range(0, 99) < lead_pct) ? lead : pick_value(), k == len - 1);
   endtask

   // full store of one value, then a tail that must be dropped
   task automatic queue_overflow_list();
      logic [VALUE_W-1:0] lead;
      lead = $urandom;
      for (int k = 0; k < DEPTH; k++)
         push_elem(lead, 1'b0);
      for (int k = 0; k < 6; k++)
         push_elem(lead ^ (32'h1 << k) ^ 32'h8000_0000, k == 5);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            absorb_element(offered);
            sent_count <= sent_count + 1;
            if ((sent_count % 64) == 63)
               idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending.size() > 0) begin
               offered = pending.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.value <= offered.value;
               req_ch.is_final <= offered.is_final;
               if (!calm && $urandom_range(0, 99) < idle_pct)
                  gap_left = $urandom_range(1, 14);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         calm <= (pending.size() < CALM_ITEMS);
      end
   end

   // result ready: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         ready_cycles++;
         if ((ready_cycles % 128) == 0)
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 13);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending: count=%0d majority=%0b",
                                    rsp_ch.max_count, rsp_ch.has_majority));
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.max_count !== want.max_count)
               flag_mismatch($sformatf("result %0d max_count got %0d want %0d",
                                       results_seen, rsp_ch.max_count, want.max_count));
            if (rsp_ch.has_majority !== want.has_majority)
               flag_mismatch($sformatf("result %0d has_majority got %0b want %0b",
                                       results_seen, rsp_ch.has_majority, want.has_majority));
         end
      end
   end

   initial begin : timeout_guard
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int rand_items;
      int lists;
      int len;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.is_final = 1'b0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;

      // single element list
      push_elem(32'h0000_0005, 1'b1);
      // two equal extremes
      push_elem(32'h7FFF_FFFF, 1'b0);
      push_elem(32'h7FFF_FFFF, 1'b1);
      // two distinct: count exactly half, no majority
      push_elem(32'h8000_0000, 1'b0);
      push_elem(32'h0000_0000, 1'b1);
      // values differing only in the sign bit
      push_elem(32'h0000_0001, 1'b0);
      push_elem(32'h8000_0001, 1'b0);
      push_elem(32'h0000_0001, 1'b1);
      // even length tie at half
      push_elem(32'hFFFF_FFFF, 1'b0);
      push_elem(32'h0000_0000, 1'b0);
      push_elem(32'hFFFF_FFFF, 1'b0);
      push_elem(32'h0000_0000, 1'b1);
      // odd length majority with alternating bit patterns
      push_elem(32'h5555_5555, 1'b0);
      push_elem(32'hAAAA_AAAA, 1'b0);
      push_elem(32'h5555_5555, 1'b0);
      push_elem(32'hAAAA_AAAA, 1'b0);
      push_elem(32'h5555_5555, 1'b1);

      rand_items = 0;
      lists = 0;
      while (rand_items < RANDOM_ITEMS) begin
         if (lists == OVERFLOW_LIST) begin
            queue_overflow_list();
            rand_items += DEPTH + 6;
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
         queue_random_list(len);
         rand_items += len;
         lists++;
      end
      total_items = pending.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (sent_count != total_items) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
